@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge unless the disable term is high.
`define ASSERT_ALWAYS(lbl, clk, dis, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the following edge.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

// Antecedent implies the consequent at the same edge.
`define ASSERT_IMPLIES(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/cor_pkg.sv @@
// Shared types, widths and pixel-order decode for the circle rasterizer.
// No dependencies; imported by the front end, queue, back end and top level.
`timescale 1ns / 1ps
`default_nettype none

package cor_pkg;

  // Job fields are sized for the widest supported configuration
  localparam int CX_W   = 16;  // center coordinate
  localparam int WR_W   = 15;  // walk offset
  localparam int PIX_W  = 14;  // emitted pixel coordinate
  localparam int CALC_W = 18;  // pixel arithmetic, wraps to PIX_W on output
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    JOB_CENTER,
    JOB_AXIS,
    JOB_OCT
  } job_kind_t;

  typedef enum logic [1:0] {
    MOVE_H,
    MOVE_D,
    MOVE_V
  } move_t;

  // One unit of work handed from front to back
  typedef struct packed {
    job_kind_t         kind;
    logic [CX_W-1:0]   cx;
    logic [CX_W-1:0]   cy;
    logic [WR_W-1:0]   x;
    logic [WR_W-1:0]   y;
    logic              fin;
  } job_t;

  // How one pixel is built from center and offsets
  typedef struct packed {
    logic swap;  // px uses y, py uses x
    logic negx;
    logic negy;
  } pt_sel_t;

  function automatic logic [2:0] job_last(input job_kind_t kind);
    logic [2:0] n;
    unique case (kind)
      JOB_CENTER: n = 3'd0;
      JOB_AXIS:   n = 3'd3;
      JOB_OCT:    n = 3'd7;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic pt_sel_t point_sel(input job_kind_t kind, input logic [2:0] k);
    pt_sel_t s;
    s = '0;
    if (kind == JOB_AXIS) begin
      unique case (k)
        3'd0:    s = '{swap: 1'b0, negx: 1'b0, negy: 1'b0};
        3'd1:    s = '{swap: 1'b0, negx: 1'b0, negy: 1'b1};
        3'd2:    s = '{swap: 1'b1, negx: 1'b0, negy: 1'b0};
        default: s = '{swap: 1'b1, negx: 1'b1, negy: 1'b0};
      endcase
    end else if (kind == JOB_OCT) begin
      unique case (k)
        3'd0:    s = '{swap: 1'b0, negx: 1'b0, negy: 1'b0};
        3'd1:    s = '{swap: 1'b0, negx: 1'b1, negy: 1'b0};
        3'd2:    s = '{swap: 1'b0, negx: 1'b1, negy: 1'b1};
        3'd3:    s = '{swap: 1'b0, negx: 1'b0, negy: 1'b1};
        3'd4:    s = '{swap: 1'b1, negx: 1'b0, negy: 1'b0};
        3'd5:    s = '{swap: 1'b1, negx: 1'b1, negy: 1'b0};
        3'd6:    s = '{swap: 1'b1, negx: 1'b1, negy: 1'b1};
        default: s = '{swap: 1'b1, negx: 1'b0, negy: 1'b1};
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cor_front.sv @@
// Command front end: holds the Bresenham walk state and turns items into jobs.
// Steps accepted while no walk is active make no job. Depends on cor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cor_front
  import cor_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   command,
  input  wire logic [COORD_BITS-1:0]  center_x,
  input  wire logic [COORD_BITS-1:0]  center_y,
  input  wire logic [RADIUS_BITS-1:0] radius,
  input  wire logic                   q_full,
  output logic                        push,
  output job_t                        push_job
);

  localparam int DW = RADIUS_BITS + 5;  // error term
  localparam int TW = DW + 2;           // error arithmetic

  logic [COORD_BITS-1:0]  held_center_x;
  logic [COORD_BITS-1:0]  held_center_y;
  logic [RADIUS_BITS-1:0] walk_x;
  logic [RADIUS_BITS-1:0] walk_y;
  logic signed [DW-1:0]   error_term;
  logic                   walking;

  logic                   accept;
  logic signed [TW-1:0]   dt, xt, yt, rt, x1t, y1t, sum_h, sum_v;
  move_t                  move;
  logic [RADIUS_BITS-1:0] x_next, y_next;
  logic signed [DW-1:0]   d_next;
  logic signed [DW-1:0]   d_start;
  logic                   fin;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Move choice and error update for one step
  always_comb begin
    dt    = TW'(error_term);
    xt    = signed'({{(TW-RADIUS_BITS){1'b0}}, walk_x});
    yt    = signed'({{(TW-RADIUS_BITS){1'b0}}, walk_y});
    rt    = signed'({{(TW-RADIUS_BITS){1'b0}}, radius});
    sum_h = dt + yt;
    sum_v = dt - xt;
    if (dt < 0) begin
      move = (sum_h <= 0) ? MOVE_H : MOVE_D;
    end else if (dt > 0) begin
      move = (sum_v <= 0) ? MOVE_D : MOVE_V;
    end else begin
      move = MOVE_D;
    end
    x_next = walk_x;
    y_next = walk_y;
    x1t    = xt + TW'(1);
    y1t    = yt - TW'(1);
    d_next = error_term;
    unique case (move)
      MOVE_H: begin
        x_next = walk_x + RADIUS_BITS'(1);
        d_next = DW'(dt + (x1t <<< 1) + TW'(1));
      end
      MOVE_D: begin
        x_next = walk_x + RADIUS_BITS'(1);
        y_next = walk_y - RADIUS_BITS'(1);
        d_next = DW'(dt + ((x1t - y1t + TW'(1)) <<< 1));
      end
      MOVE_V: begin
        y_next = walk_y - RADIUS_BITS'(1);
        d_next = DW'(dt - (y1t <<< 1) + TW'(1));
      end
      default: d_next = error_term;
    endcase
    fin     = y_next < x_next;
    d_start = DW'(TW'(2) - (rt <<< 1));
  end

  // Job built from the current item
  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (!command) begin
      push         = accept;
      push_job.cx  = CX_W'(center_x);
      push_job.cy  = CX_W'(center_y);
      push_job.x   = '0;
      push_job.y   = WR_W'(radius);
      if (radius == '0) begin
        push_job.kind = JOB_CENTER;
        push_job.fin  = 1'b1;
      end else begin
        push_job.kind = JOB_AXIS;
        push_job.fin  = 1'b0;
      end
    end else begin
      push          = accept && walking;
      push_job.kind = JOB_OCT;
      push_job.cx   = CX_W'(held_center_x);
      push_job.cy   = CX_W'(held_center_y);
      push_job.x    = WR_W'(x_next);
      push_job.y    = WR_W'(y_next);
      push_job.fin  = fin;
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x <= '0;
      held_center_y <= '0;
      walk_x        <= '0;
      walk_y        <= '0;
      error_term    <= '0;
      walking       <= 1'b0;
    end else if (accept) begin
      if (!command) begin
        held_center_x <= center_x;
        held_center_y <= center_y;
        walk_x        <= '0;
        if (radius == '0) begin
          walk_y     <= '0;
          error_term <= '0;
          walking    <= 1'b0;
        end else begin
          walk_y     <= radius;
          error_term <= d_start;
          walking    <= 1'b1;
        end
      end else if (walking) begin
        walk_x     <= x_next;
        walk_y     <= y_next;
        error_term <= d_next;
        if (fin) begin
          walking <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cor_queue.sv @@
// Two-entry job queue between the command front end and the pixel back end.
// Depends on cor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cor_queue
  import cor_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cor_back.sv @@
// Pixel back end: expands each job into its mirrored pixels, one per cycle
// while out_ready does not stall the output register. Depends on cor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cor_back
  import cor_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  job_t                    head,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [PIX_W-1:0] pixel_x,
  output logic signed [PIX_W-1:0] pixel_y,
  output logic                    last_of_run,
  output logic                    finished
);

  logic [2:0]                idx;
  logic                      emit;
  logic                      is_last;
  pt_sel_t                   sel;
  logic [WR_W-1:0]           a, b;
  logic signed [CALC_W-1:0]  at, bt, cxt, cyt, px, py;

  assign emit    = !empty && (!out_valid || out_ready);
  assign is_last = idx == job_last(head.kind);
  assign pop     = emit && is_last;

  // Mirrored point for the current index
  always_comb begin
    sel = point_sel(head.kind, idx);
    a   = sel.swap ? head.y : head.x;
    b   = sel.swap ? head.x : head.y;
    at  = signed'(CALC_W'(a));
    bt  = signed'(CALC_W'(b));
    cxt = signed'(CALC_W'(head.cx));
    cyt = signed'(CALC_W'(head.cy));
    px  = sel.negx ? cxt - at : cxt + at;
    py  = sel.negy ? cyt - bt : cyt + bt;
  end

  // Pixel index within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (emit) begin
      idx <= is_last ? 3'd0 : idx + 3'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x     <= px[PIX_W-1:0];
      pixel_y     <= py[PIX_W-1:0];
      last_of_run <= is_last;
      finished    <= is_last && head.fin;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/circle_outline_rasterizer_unit.sv @@
// Bresenham circle outline rasterizer, top level.
// An accepted item is registered in the job queue, then its pixels in the output register.
// Pixels leave one per cycle unless m_tready stalls: eight per step, four per start, one
// per zero-radius start. A two-entry job queue lets the front take items while pixels drain.
// Reset: synchronous rst clears the walk state (idle), the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module circle_outline_rasterizer_unit
  import cor_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  localparam int IN_DATA_W  = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // center_x, center_y, radius, zero pad
  input  wire logic                  s_tuser,   // command
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // pixel_x, pixel_y, zero pad
  output logic                       m_tlast,   // last_of_run
  output logic                       m_tuser    // finished
);

  logic                    q_full;
  logic                    q_empty;
  logic                    push;
  logic                    pop;
  job_t                    push_job;
  job_t                    head;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;

  cor_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .command  (s_tuser),
    .center_x (s_tdata[COORD_BITS-1:0]),
    .center_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius   (s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  cor_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  cor_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last_of_run (m_tlast),
    .finished    (m_tuser)
  );

  assign m_tdata = {{(OUT_DATA_W-2*PIX_W){1'b0}}, pixel_y, pixel_x};

endmodule

`default_nettype wire

@@ rtl/core/cor_checker.sv @@
// Port-level checks for the circle rasterizer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cor_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  logic stall;

  assign stall = m_tvalid && !m_tready;

  // A finished outline only shows on the last pixel of an item
  `ASSERT_IMPLIES(a_fin_last, clk, rst, m_tvalid && m_tuser, m_tlast, "finished without last")

  // Reset leaves no pixel pending
  `ASSERT_NEXT(a_rst_idle, clk, 1'b0, rst, !m_tvalid, "pixel valid after reset")

  // A stalled pixel holds
  `ASSERT_NEXT(a_hold, clk, rst, stall, m_tvalid && $stable(m_tdata), "stalled pixel changed")
  `ASSERT_NEXT(a_flags, clk, rst, stall, $stable({m_tlast, m_tuser}), "stalled flags changed")

  // Padding bits above the two coordinates stay zero
  `ASSERT_ALWAYS(a_pad, clk, rst, !m_tvalid || m_tdata[31:28] == 4'd0, "nonzero tdata padding")

endmodule

bind circle_outline_rasterizer_unit cor_checker u_cor_checker (.*);

`default_nettype wire

@@ tb/circle_outline_rasterizer_unit_test.sv @@
// Self-checking testbench for circle_outline_rasterizer_unit: start/step items in,
// predicted outline pixels checked in order. Depends on cor_pkg and the unit's RTL.
`timescale 1ns / 1ps

module circle_outline_rasterizer_unit_test;
  import cor_pkg::*;

  localparam int COORD_W = 12;
  localparam int RAD_W   = 11;
  localparam int IN_W    = ((2 * COORD_W + RAD_W + 7) / 8) * 8;
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;
  localparam int TARGET_ITEMS = 380;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             fin;
  } pixel_t;

  // Outline predictor plus the queue of pixels still owed by the unit
  class outline_scoreboard;
    logic [COORD_W-1:0] held_cx, held_cy;
    logic [COORD_W-1:0] walk_x;
    logic [COORD_W:0]   walk_y;
    logic signed [15:0] err;
    bit                 walking;
    pixel_t             expected_pixels[$];
    int errors, n_starts, n_steps, n_finished, n_checked;
    int move_count[3];

    function new();
      held_cx = '0; held_cy = '0; walk_x = '0; walk_y = '0; err = '0;
      walking = 0;
      errors = 0; n_starts = 0; n_steps = 0; n_finished = 0; n_checked = 0;
      move_count = '{0, 0, 0};
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void add_pixel(int px, int py, bit last, bit fin);
      pixel_t p;
      p.px = px[PIX_W-1:0];
      p.py = py[PIX_W-1:0];
      p.last = last;
      p.fin = fin;
      expected_pixels.push_back(p);
    endfunction

    // Work out the pixels caused by one accepted item
    function void predict_item(logic cmd, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [RAD_W-1:0] r);
      int x, y, d, ox, oy;
      move_t mv;
      bit fin;
      if (cmd == CMD_START) begin
        n_starts++;
        held_cx = cx;
        held_cy = cy;
        ox = int'(cx);
        oy = int'(cy);
        y = int'(r);
        if (r == 0) begin
          walk_x = '0; walk_y = '0; err = '0; walking = 0;
          n_finished++;
          add_pixel(ox, oy, 1, 1);
          return;
        end
        walk_x = '0;
        walk_y = r;
        err = 16'(2 * (1 - y));
        walking = 1;
        add_pixel(ox, oy + y, 0, 0);
        add_pixel(ox, oy - y, 0, 0);
        add_pixel(ox + y, oy, 0, 0);
        add_pixel(ox - y, oy, 1, 0);
        return;
      end
      // step while idle is dropped
      if (!walking) return;
      n_steps++;
      x = int'(walk_x);
      y = int'(walk_y);
      d = int'(err);
      ox = int'(held_cx);
      oy = int'(held_cy);
      if (d < 0) mv = (2 * (d + y) - 1 < 0) ? MOVE_H : MOVE_D;
      else if (d > 0) mv = (2 * (d - x) - 1 < 0) ? MOVE_D : MOVE_V;
      else mv = MOVE_D;
      case (mv)
        MOVE_H: begin
          x++;
          d += 2 * x + 1;
          move_count[0]++;
        end
        MOVE_D: begin
          x++;
          y--;
          d += 2 * (x - y + 1);
          move_count[1]++;
        end
        default: begin
          y--;
          d += -2 * y + 1;
          move_count[2]++;
        end
      endcase
      walk_x = x[COORD_W-1:0];
      walk_y = y[COORD_W:0];
      err = d[15:0];
      fin = (y < x);
      if (fin) begin
        walking = 0;
        n_finished++;
      end
      // eight-way mirror, same order as the unit emits
      add_pixel(ox + x, oy + y, 0, 0);
      add_pixel(ox - x, oy + y, 0, 0);
      add_pixel(ox - x, oy - y, 0, 0);
      add_pixel(ox + x, oy - y, 0, 0);
      add_pixel(ox + y, oy + x, 0, 0);
      add_pixel(ox - y, oy + x, 0, 0);
      add_pixel(ox - y, oy - x, 0, 0);
      add_pixel(ox + y, oy - x, 1, fin);
    endfunction

    // Compare one accepted pixel with the oldest expectation
    function void check_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, logic last,
                              logic fin);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d last=%0b finished=%0b",
               $signed(px), $signed(py), last, fin);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      n_checked++;
      if (px !== want.px) begin
        $error("pixel_x expected %0d actual %0d", $signed(want.px), $signed(px));
        errors++;
      end
      if (py !== want.py) begin
        $error("pixel_y expected %0d actual %0d", $signed(want.py), $signed(py));
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run expected %0b actual %0b", want.last, last);
        errors++;
      end
      if (fin !== want.fin) begin
        $error("finished expected %0b actual %0b", want.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;  // center_x, center_y, radius, zero pad
  logic                  s_tuser = 1'b0;  // command
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;  // pixel_x, pixel_y, zero pad
  logic                  m_tlast;  // last_of_run
  logic                  m_tuser;  // finished

  outline_scoreboard board = new();
  bit calm = 0;      // no idling on either side
  bit hold_req = 0;  // ask the receiver for a long hold-off
  int live_items = 0;

  circle_outline_rasterizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Result side: check every accepted pixel
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_pixel(m_tdata[PIX_W-1:0], m_tdata[2*PIX_W-1:PIX_W], m_tlast, m_tuser);
  end

  // Receiver: random stalls, calm stretch, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 19);
      @(negedge clk);
    end
  end

  // Offer one item and hold it until accepted; returns at a falling edge
  task automatic offer_item(logic cmd, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [RAD_W-1:0] r);
    if (!calm && $urandom_range(0, 99) < 19) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_W'({r, cy, cx});
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_START || board.walking) live_items++;
    board.predict_item(cmd, cx, cy, r);
    @(negedge clk);
  endtask

  task automatic offer_step();
    offer_item(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom));
  endtask

  // Start a circle and step it until finished or max_steps were sent
  task automatic draw_circle(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [RAD_W-1:0] r, int max_steps);
    int n;
    n = 0;
    offer_item(CMD_START, cx, cy, r);
    while (board.walking && n < max_steps) begin
      offer_step();
      n++;
    end
  endtask

  // Stop sending until every owed pixel has come out
  task automatic drain_wait();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int seq, pick;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle step, zero radius at the corners, extreme radius, abandon, full walks
    offer_step();
    draw_circle('0, '0, '0, 0);
    draw_circle('1, '1, '0, 0);
    draw_circle(12'd4095, 12'd0, 11'd2047, 3);
    draw_circle(12'd0, 12'd4095, 11'd1, 10);
    offer_step();
    draw_circle(12'd2048, 12'd2048, 11'd2, 10);
    draw_circle('0, '0, '1, 2);
    draw_circle(12'd4095, 12'd4095, 11'd5, 10);
    offer_step();
    drain_wait();

    // random: mostly complete small circles, some large or abandoned ones, some noise
    seq = 0;
    while (live_items < TARGET_ITEMS) begin
      seq++;
      calm = (seq >= 20 && seq < 32);
      if (seq == 8) begin
        hold_req = 1;
        draw_circle(COORD_W'($urandom), COORD_W'($urandom),
                    RAD_W'($urandom_range(1500, 2047)), 24);
      end
      if (seq % 15 == 0) drain_wait();
      pick = $urandom_range(0, 99);
      if (pick < 70)
        draw_circle(COORD_W'($urandom), COORD_W'($urandom),
                    RAD_W'($urandom_range(1, 20)), 1000);
      else if (pick < 80)
        draw_circle(COORD_W'($urandom), COORD_W'($urandom),
                    RAD_W'($urandom_range(0, 2047)), $urandom_range(1, 10));
      else if (pick < 88)
        draw_circle(COORD_W'($urandom), COORD_W'($urandom),
                    RAD_W'($urandom_range(0, 20)), $urandom_range(0, 3));
      else
        repeat ($urandom_range(1, 3)) offer_step();
    end
    calm = 0;

    drain_wait();
    repeat (16) @(posedge clk);
    $display("Run covered %0d starts and %0d walk steps (moves H/D/V: %0d/%0d/%0d).",
             board.n_starts, board.n_steps, board.move_count[0], board.move_count[1],
             board.move_count[2]);
    $display("%0d circles completed, %0d pixels compared.", board.n_finished,
             board.n_checked);
    if (board.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $error("run did not complete in time, %0d pixels still owed", board.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
